// ===== rtl/core/lcp_pkg.sv =====
// shared constants, codes and types for the pinned lru cache
`timescale 1ns / 1ps
`default_nettype none
package lcp_pkg;
  localparam int DEPTH_DEF     = 256;
  localparam int CHANNELS_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int CH_W    = 4;
  localparam int GROUP_W = 3;
  localparam int CAP_W   = 9;
  localparam int STAT_W  = 3;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 9'd256;
  localparam logic [GROUP_W-1:0] GROUP_MIXED = 3'd7;

  localparam logic [STAT_W-1:0] STAT_HIT      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISS     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_PINNED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_LOADFAIL = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RELEASED = 3'd4;

  localparam logic [0:0] OP_REQUEST = 1'b0;
  localparam logic [0:0] OP_RELEASE = 1'b1;

  typedef struct packed {
    logic            bind_en;
    logic            release_ch;
    logic [CH_W-1:0] ch;
  } lcp_bind_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/lcp_bind.sv =====
// channel binding table with a parallel pinned check for one slot
`timescale 1ns / 1ps
`default_nettype none
module lcp_bind #(
  parameter int DEPTH    = lcp_pkg::DEPTH_DEF,
  parameter int CHANNELS = lcp_pkg::CHANNELS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lcp_pkg::lcp_bind_req_t     req_i,
  input  wire logic [$clog2(DEPTH)-1:0]   slot_i,
  input  wire logic [$clog2(DEPTH)-1:0]   probe_i,
  output logic                            pinned_o
);
  import lcp_pkg::*;
  localparam int IDXW = $clog2(DEPTH);

  logic [CHANNELS-1:0] valid_q;
  logic [IDXW-1:0]     slot_q [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (int'(req_i.ch) == c) begin
          if (req_i.release_ch) begin
            valid_q[c] <= 1'b0;
          end else if (req_i.bind_en) begin
            valid_q[c] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (req_i.bind_en && int'(req_i.ch) == c) begin
        slot_q[c] <= slot_i;
      end
    end
  end

  always_comb begin
    pinned_o = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (valid_q[c] && slot_q[c] == probe_i) begin
        pinned_o = 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/lru_cache_with_pinned_entries.sv =====
// top level: recency-ordered cache with channel pinning, sequenced over one table port
`timescale 1ns / 1ps
`default_nettype none
// Fully associative cache kept as a recency-ordered table (position 0 most recent), one
// memory with one read and one write port; each position holds slot, key and group.
// A request runs a lookup scan from the front; on a miss it runs a victim scan from
// the back when the table is full and, if the load succeeds, a search for the lowest
// free slot. The positions ahead of the entry then move down one by one while it goes
// to the front (or the gap closes on an evict with a failed load). A release only
// clears the channel's binding. The block takes no request while one is in progress;
// a finished result waits in an output register and the next request may be taken
// meanwhile.
module lru_cache_with_pinned_entries #(
  parameter int DEPTH     = lcp_pkg::DEPTH_DEF,
  parameter int CHANNELS  = lcp_pkg::CHANNELS_DEF,
  parameter int KEY_WIDTH = lcp_pkg::KEY_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // key[31:0], group[34:32], channel[38:35], load_ok[39]
  input  wire logic [0:0]  s_axis_tuser,  // opcode[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // entry_index[7:0], evicted[8], evicted_key[40:9]
  output logic [2:0]       m_axis_tuser,  // status[2:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lcp_pkg::*;

  localparam int IDXW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int EW   = IDXW + KEY_WIDTH + GROUP_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LRD  = 4'd1;
  localparam logic [3:0] S_LCMP = 4'd2;
  localparam logic [3:0] S_VRD  = 4'd3;
  localparam logic [3:0] S_VCMP = 4'd4;
  localparam logic [3:0] S_FREE = 4'd5;
  localparam logic [3:0] S_MRD  = 4'd6;
  localparam logic [3:0] S_MWR  = 4'd7;
  localparam logic [3:0] S_MFR  = 4'd8;
  localparam logic [3:0] S_RRD  = 4'd9;
  localparam logic [3:0] S_RWR  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  // configuration
  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-CAP_W){1'b0}}, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // recency table
  logic [EW-1:0]   mem [DEPTH];
  logic            mem_we;
  logic [IDXW-1:0] mem_wa, mem_ra;
  logic [EW-1:0]   mem_wd, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  logic [IDXW-1:0]      rd_slot;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [GROUP_W-1:0]   rd_grp;
  assign rd_slot = rdata_q[EW-1 -: IDXW];
  assign rd_key  = rdata_q[GROUP_W +: KEY_WIDTH];
  assign rd_grp  = rdata_q[GROUP_W-1:0];

  // sequencer state
  logic [3:0]           state_q, state_d;
  logic [CNTW-1:0]      cnt_q, cnt_d, pos_q, pos_d;
  logic [IDXW-1:0]      fs_q, fs_d, slot_q, slot_d;
  logic [DEPTH-1:0]     used_q, used_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [GROUP_W-1:0]   grp_q, grp_d, egrp_q, egrp_d;
  logic [CH_W-1:0]      ch_q, ch_d;
  logic                 ld_q, ld_d;
  logic [STAT_W-1:0]    stat_q, stat_d;
  logic [7:0]           idx_q, idx_d;
  logic                 ev_q, ev_d;
  logic [31:0]          evkey_q, evkey_d;
  logic                 full;
  logic                 pinned;
  lcp_bind_req_t        bind_req;
  logic [IDXW-1:0]      bind_slot;

  // output register
  logic        m_valid_q, m_valid_d;
  logic [47:0] m_data_q, m_data_d;
  logic [2:0]  m_user_q, m_user_d;

  assign full = (int'(cnt_q) >= int'(cap_q)) || (int'(cnt_q) == DEPTH);

  lcp_bind #(.DEPTH(DEPTH), .CHANNELS(CHANNELS)) u_bind (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bind_req),
    .slot_i  (bind_slot),
    .probe_i (rd_slot),
    .pinned_o(pinned)
  );

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    fs_d      = fs_q;
    slot_d    = slot_q;
    used_d    = used_q;
    key_d     = key_q;
    grp_d     = grp_q;
    egrp_d    = egrp_q;
    ch_d      = ch_q;
    ld_d      = ld_q;
    stat_d    = stat_q;
    idx_d     = idx_q;
    ev_d      = ev_q;
    evkey_d   = evkey_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_we    = 1'b0;
    mem_wa    = pos_q[IDXW-1:0];
    mem_wd    = rdata_q;
    mem_ra    = pos_q[IDXW-1:0];
    bind_req  = '{bind_en: 1'b0, release_ch: 1'b0, ch: ch_q};
    bind_slot = slot_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          key_d   = KEY_WIDTH'(s_axis_tdata[31:0]);
          grp_d   = s_axis_tdata[34:32];
          ch_d    = s_axis_tdata[38:35];
          ld_d    = s_axis_tdata[39];
          ev_d    = 1'b0;
          evkey_d = '0;
          idx_d   = '0;
          pos_d   = '0;
          if (s_axis_tuser == OP_RELEASE) begin
            bind_req = '{bind_en: 1'b0, release_ch: 1'b1, ch: s_axis_tdata[38:35]};
            stat_d   = STAT_RELEASED;
            state_d  = S_DONE;
          end else begin
            state_d = S_LRD;
          end
        end
      end
      S_LRD: begin
        if (pos_q == cnt_q) begin
          if (full) begin
            state_d = S_VRD;
          end else if (!ld_q) begin
            stat_d  = STAT_LOADFAIL;
            state_d = S_DONE;
          end else begin
            fs_d    = '0;
            state_d = S_FREE;
          end
        end else begin
          state_d = S_LCMP;
        end
      end
      S_LCMP: begin
        if (rd_key == key_q) begin
          slot_d    = rd_slot;
          egrp_d    = (rd_grp != grp_q) ? GROUP_MIXED : rd_grp;
          stat_d    = STAT_HIT;
          idx_d     = 8'(rd_slot);
          bind_req  = '{bind_en: 1'b1, release_ch: 1'b0, ch: ch_q};
          bind_slot = rd_slot;
          state_d   = (pos_q == '0) ? S_MFR : S_MRD;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = S_LRD;
        end
      end
      S_VRD: begin
        mem_ra = IDXW'(pos_q - 1'b1);
        if (pos_q == '0) begin
          stat_d  = STAT_PINNED;
          state_d = S_DONE;
        end else begin
          state_d = S_VCMP;
        end
      end
      S_VCMP: begin
        pos_d = pos_q - 1'b1;
        if (pinned) begin
          state_d = S_VRD;
        end else begin
          ev_d            = 1'b1;
          evkey_d         = 32'(rd_key);
          used_d[rd_slot] = 1'b0;
          if (!ld_q) begin
            stat_d  = STAT_LOADFAIL;
            state_d = S_RRD;
          end else begin
            fs_d    = '0;
            state_d = S_FREE;
          end
        end
      end
      S_FREE: begin
        if (!used_q[fs_q]) begin
          used_d[fs_q] = 1'b1;
          slot_d       = fs_q;
          egrp_d       = grp_q;
          stat_d       = STAT_MISS;
          idx_d        = 8'(fs_q);
          bind_req     = '{bind_en: 1'b1, release_ch: 1'b0, ch: ch_q};
          bind_slot    = fs_q;
          if (!ev_q) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = (pos_q == '0) ? S_MFR : S_MRD;
        end else begin
          fs_d = fs_q + 1'b1;
        end
      end
      S_MRD: begin
        mem_ra  = IDXW'(pos_q - 1'b1);
        state_d = S_MWR;
      end
      S_MWR: begin
        mem_we  = 1'b1;
        pos_d   = pos_q - 1'b1;
        state_d = (pos_q == CNTW'(1)) ? S_MFR : S_MRD;
      end
      S_MFR: begin
        mem_we  = 1'b1;
        mem_wa  = '0;
        mem_wd  = {slot_q, key_q, egrp_q};
        state_d = S_DONE;
      end
      S_RRD: begin
        // close the gap left by the victim
        mem_ra = IDXW'(pos_q + 1'b1);
        if (int'(pos_q) + 1 >= int'(cnt_q)) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_RWR;
        end
      end
      S_RWR: begin
        mem_we  = 1'b1;
        pos_d   = pos_q + 1'b1;
        state_d = S_RRD;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {7'd0, evkey_q, ev_q, idx_q};
          m_user_d  = stat_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      used_q    <= used_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    fs_q     <= fs_d;
    slot_q   <= slot_d;
    key_q    <= key_d;
    grp_q    <= grp_d;
    egrp_q   <= egrp_d;
    ch_q     <= ch_d;
    ld_q     <= ld_d;
    stat_q   <= stat_d;
    idx_q    <= idx_d;
    ev_q     <= ev_d;
    evkey_q  <= evkey_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= DEPTH)
    else $error("entry count above depth");

  a_free_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE && !used_q[fs_q]) |=> (used_q[slot_q] && state_q != S_FREE))
    else $error("free slot not claimed");

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result raised outside done");

  a_evict_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |->
      (m_axis_tuser == STAT_MISS || m_axis_tuser == STAT_LOADFAIL))
    else $error("eviction with wrong status");
endmodule
`default_nettype wire
